/* rtl/assert_macros.svh */
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, checked on every rising edge outside reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

/* rtl/bvm_pkg.sv */
package bvm_pkg;

  localparam int unsigned TICK_MS_DEF = 100;

  localparam int unsigned ADC_W   = 12;
  localparam int unsigned MV_W    = 15;
  localparam int unsigned FRAC_W  = 16;
  localparam int unsigned Q_W     = 31;
  localparam int unsigned SCALE_W = 26;
  localparam int unsigned DIV_N_W = SCALE_W + FRAC_W;
  localparam int unsigned COEF_W  = 16;
  localparam int unsigned PROD_W  = Q_W + COEF_W;
  localparam int unsigned GRB_W   = 24;
  localparam int unsigned PER_W   = 16;
  localparam int unsigned SEQ_W   = 16;
  localparam int unsigned CFG_W   = 16;

  localparam logic [13:0]        MV_SCALE  = 14'd13310;
  localparam logic [ADC_W-1:0]   VREF_HIGH = 12'd4095;
  localparam logic [DIV_N_W-1:0] RD_MAX    = DIV_N_W'(64'd20000 << 16);
  localparam logic [Q_W-1:0]     FLOOR_Q   = Q_W'(64'd4900 << 16);
  localparam logic [Q_W:0]       HALF_LSB  = (Q_W+1)'(32768);
  localparam logic [COEF_W-1:0]  EMA_NEW   = 16'd3277;
  localparam logic [COEF_W-1:0]  EMA_OLD   = 16'd62259;

  localparam logic [MV_W-1:0] TH_HI  = 15'd7900;
  localparam logic [MV_W-1:0] TH_MID = 15'd7600;
  localparam logic [MV_W-1:0] TH_LO  = 15'd7400;
  localparam logic [MV_W-1:0] HYST   = 15'd50;

  localparam logic [1:0] BAND_RED    = 2'd0;
  localparam logic [1:0] BAND_ORANGE = 2'd1;
  localparam logic [1:0] BAND_YELLOW = 2'd2;
  localparam logic [1:0] BAND_GREEN  = 2'd3;

  typedef enum logic [1:0] {
    REG_HB_PERIOD,
    REG_LOW_LIMIT,
    REG_STREAM_EN,
    REG_STREAM_PERIOD
  } reg_index_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIVIDE,
    ST_MUL_OLD,
    ST_MUL_NEW,
    ST_SUM,
    ST_TRACK
  } state_t;

  typedef struct packed {
    logic             we;
    reg_index_t       index;
    logic [CFG_W-1:0] data;
  } cfg_bus_t;

  typedef struct packed {
    logic [MV_W-1:0]  mv;
    logic [1:0]       band;
    logic             changed;
    logic [GRB_W-1:0] grb;
    logic             hb;
    logic [MV_W-1:0]  rep;
    logic             frame;
    logic [SEQ_W-1:0] seq;
    logic             alarm;
  } trk_result_t;

  function automatic logic [GRB_W-1:0] band_grb(input logic [1:0] band);
    logic [GRB_W-1:0] grb;
    unique case (band)
      BAND_GREEN:  grb = 24'h300000;
      BAND_YELLOW: grb = 24'h202000;
      BAND_ORANGE: grb = 24'h103000;
      default:     grb = 24'h003000;
    endcase
    return grb;
  endfunction

endpackage

/* rtl/bvm_divider.sv */
module bvm_divider (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [bvm_pkg::DIV_N_W-1:0]   dividend,
  input  logic [bvm_pkg::ADC_W-1:0]     divisor,
  output logic                          done,
  output logic [bvm_pkg::DIV_N_W-1:0]   quotient
);
  import bvm_pkg::*;

  localparam int unsigned CNT_W = $clog2(DIV_N_W);

  logic               busy;
  logic [CNT_W-1:0]   cnt;
  logic [ADC_W-1:0]   rem;
  logic [ADC_W-1:0]   dsor;
  logic [DIV_N_W-1:0] quo;
  logic [ADC_W:0]     shifted;
  logic [ADC_W:0]     trial;
  logic               fits;

  assign shifted  = {rem, quo[DIV_N_W-1]};
  assign trial    = shifted - {1'b0, dsor};
  assign fits     = shifted >= {1'b0, dsor};
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(DIV_N_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= '0;
      dsor <= divisor;
      quo  <= dividend;
    end else if (busy) begin
      rem <= fits ? trial[ADC_W-1:0] : shifted[ADC_W-1:0];
      quo <= {quo[DIV_N_W-2:0], fits};
    end
  end

endmodule

/* rtl/bvm_track.sv */
module bvm_track #(
  parameter int unsigned TICK_MS = bvm_pkg::TICK_MS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  bvm_pkg::cfg_bus_t         cfg,
  input  logic                      step,
  input  logic [bvm_pkg::Q_W-1:0]   filter,
  output bvm_pkg::trk_result_t      result
);
  import bvm_pkg::*;

  localparam int unsigned LIMIT_TICKS = 10000 / TICK_MS;
  localparam int unsigned LC_W        = $clog2(LIMIT_TICKS + 2);
  localparam logic [PER_W:0] TICK_E   = (PER_W+1)'(TICK_MS);

  logic [PER_W-1:0] hb_period;
  logic [MV_W-1:0]  low_limit;
  logic             stream_en;
  logic [PER_W-1:0] stream_period;

  logic [1:0]       band_reg;
  logic             band_valid;
  logic [PER_W-1:0] hb_elapsed;
  logic [LC_W-1:0]  low_count;
  logic [PER_W-1:0] stream_elapsed;
  logic [SEQ_W-1:0] stream_seq;

  logic [1:0]       band_next;
  logic [PER_W-1:0] hb_elapsed_next;
  logic [LC_W-1:0]  low_count_next;
  logic [LC_W-1:0]  count_inc;
  logic [PER_W-1:0] stream_elapsed_next;
  logic [SEQ_W-1:0] stream_seq_next;
  logic [PER_W:0]   hb_sum;
  logic [PER_W:0]   stream_sum;
  logic [PER_W-1:0] stream_per;
  logic [Q_W:0]     rep_sum;
  logic [MV_W-1:0]  mv;
  logic             low_now;

  always_comb begin
    mv      = filter[Q_W-1:FRAC_W];
    rep_sum = {1'b0, filter} + HALF_LSB;

    band_next = band_reg;
    if (!band_valid) begin
      if (mv < TH_LO)       band_next = BAND_RED;
      else if (mv < TH_MID) band_next = BAND_ORANGE;
      else if (mv < TH_HI)  band_next = BAND_YELLOW;
      else                  band_next = BAND_GREEN;
    end else begin
      unique case (band_reg)
        BAND_GREEN: begin
          if (mv < TH_HI - HYST) band_next = BAND_YELLOW;
        end
        BAND_YELLOW: begin
          if (mv >= TH_HI + HYST)       band_next = BAND_GREEN;
          else if (mv < TH_MID - HYST)  band_next = BAND_ORANGE;
        end
        BAND_ORANGE: begin
          if (mv >= TH_MID + HYST)      band_next = BAND_YELLOW;
          else if (mv < TH_LO - HYST)   band_next = BAND_RED;
        end
        default: begin
          if (mv >= TH_LO + HYST) band_next = BAND_ORANGE;
        end
      endcase
    end

    result.mv      = mv;
    result.band    = band_next;
    result.changed = !band_valid || (band_next != band_reg);
    result.grb     = band_grb(band_next);
    result.rep     = rep_sum[Q_W-1:FRAC_W];

    hb_sum          = {1'b0, hb_elapsed} + TICK_E;
    result.hb       = 1'b0;
    hb_elapsed_next = '0;
    if (hb_period != '0) begin
      if (hb_sum >= {1'b0, hb_period}) begin
        result.hb = 1'b1;
      end else begin
        hb_elapsed_next = hb_sum[PER_W-1:0];
      end
    end

    low_now        = (filter < {low_limit, {FRAC_W{1'b0}}}) && (filter > FLOOR_Q);
    count_inc      = low_now ? low_count + 1'b1 : '0;
    result.alarm   = count_inc > LC_W'(LIMIT_TICKS);
    low_count_next = result.alarm ? '0 : count_inc;

    stream_per          = (stream_period < TICK_E[PER_W-1:0]) ? TICK_E[PER_W-1:0]
                                                              : stream_period;
    stream_sum          = {1'b0, stream_elapsed} + TICK_E;
    stream_elapsed_next = stream_elapsed;
    stream_seq_next     = stream_seq;
    result.frame        = 1'b0;
    result.seq          = '0;
    if (stream_en) begin
      if (stream_sum >= {1'b0, stream_per}) begin
        stream_elapsed_next = '0;
        result.frame        = 1'b1;
        result.seq          = stream_seq;
        stream_seq_next     = stream_seq + 1'b1;
      end else begin
        stream_elapsed_next = stream_sum[PER_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hb_period      <= '0;
      low_limit      <= 15'd6300;
      stream_en      <= 1'b0;
      stream_period  <= '0;
      band_reg       <= BAND_RED;
      band_valid     <= 1'b0;
      hb_elapsed     <= '0;
      low_count      <= '0;
      stream_elapsed <= '0;
      stream_seq     <= '0;
    end else begin
      if (step) begin
        band_reg       <= band_next;
        band_valid     <= 1'b1;
        hb_elapsed     <= hb_elapsed_next;
        low_count      <= low_count_next;
        stream_elapsed <= stream_elapsed_next;
        stream_seq     <= stream_seq_next;
      end
      if (cfg.we) begin
        unique case (cfg.index)
          REG_HB_PERIOD:     hb_period <= cfg.data;
          REG_LOW_LIMIT:     low_limit <= cfg.data[MV_W-1:0];
          REG_STREAM_EN: begin
            stream_en      <= cfg.data[0];
            stream_elapsed <= '0;
            stream_seq     <= '0;
          end
          REG_STREAM_PERIOD: stream_period <= cfg.data;
          default: ;
        endcase
      end
    end
  end

endmodule

/* rtl/battery_voltage_monitor.sv */
// Battery voltage monitor.
// The input channel (in_valid, in_stall, vref_raw, vbat_raw) carries one ADC
// tick per transfer. Each tick yields exactly one result transfer on the
// output channel (out_valid, out_stall and the result fields).
// A tick with a usable reference runs the restoring divider for the reading,
// then the ST_MUL_OLD, ST_MUL_NEW and ST_SUM steps of multiply and add for the
// moving average, or loads the reading directly while the filter is zero. A
// tick with a reference of zero or full scale skips the arithmetic and goes
// straight from the check state to the result state.
// One tick is worked at a time; in_stall stays high until the sequencer is
// back in its idle state, so no tick is taken before the last has its result.
// Results sit in an output register, so the next tick is taken while a result
// waits; if the receiver still stalls when the next result is done, the block
// holds that result internally and keeps in_stall high.
// Configuration writes through cfg_we, cfg_index and cfg_data take effect at
// the clock edge; the user must make them only while the block is idle (not enforced).
// Synchronous reset clears the filter, band, timers and configuration to
// their reset values and empties the output register.

`include "assert_macros.svh"

module battery_voltage_monitor #(
  parameter int unsigned TICK_MS = bvm_pkg::TICK_MS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [11:0] vref_raw,
  input  logic [11:0] vbat_raw,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [14:0] filtered_mv,
  output logic [1:0]  led_band,
  output logic        band_changed,
  output logic [23:0] led_grb,
  output logic        heartbeat_report,
  output logic [14:0] report_mv,
  output logic        stream_frame,
  output logic [15:0] frame_seq,
  output logic        alarm,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import bvm_pkg::*;

  state_t state;
  state_t state_next;

  logic [ADC_W-1:0]   vref_q;
  logic [ADC_W-1:0]   vbat_q;
  logic [Q_W-1:0]     filter;
  logic [Q_W-1:0]     rd;
  logic [PROD_W-1:0]  prod;
  logic [PROD_W-1:0]  acc;
  logic [PROD_W:0]    ema_sum;
  logic [Q_W-1:0]     mul_a;
  logic [COEF_W-1:0]  mul_b;
  logic [SCALE_W-1:0] scaled;
  logic [DIV_N_W-1:0] dividend;
  logic [DIV_N_W-1:0] quotient;
  logic [Q_W-1:0]     rd_clamped;
  logic               div_start;
  logic               div_done;
  logic               vref_ok;
  logic               trk_step;
  logic               out_free;
  cfg_bus_t           cfg;
  trk_result_t        trk_result;
  trk_result_t        out_q;

  assign cfg        = '{we: cfg_we, index: reg_index_t'(cfg_index), data: cfg_data};
  assign vref_ok    = (vref_q != '0) && (vref_q != VREF_HIGH);
  assign scaled     = SCALE_W'(MV_SCALE) * SCALE_W'(vbat_q);
  assign dividend   = {scaled, {FRAC_W{1'b0}}};
  assign rd_clamped = (quotient > RD_MAX) ? '0 : quotient[Q_W-1:0];
  assign mul_a      = (state == ST_MUL_OLD) ? filter : rd;
  assign mul_b      = (state == ST_MUL_OLD) ? EMA_OLD : EMA_NEW;
  assign ema_sum    = {1'b0, acc} + {1'b0, prod};
  assign out_free   = !out_valid || !out_stall;
  assign in_stall   = (state != ST_IDLE);

  bvm_divider u_divider (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (dividend),
    .divisor  (vref_q),
    .done     (div_done),
    .quotient (quotient)
  );

  bvm_track #(
    .TICK_MS (TICK_MS)
  ) u_track (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .step   (trk_step),
    .filter (filter),
    .result (trk_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    div_start  = 1'b0;
    trk_step   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_CHECK;
      end
      ST_CHECK: begin
        if (vref_ok) begin
          div_start  = 1'b1;
          state_next = ST_DIVIDE;
        end else begin
          state_next = ST_TRACK;
        end
      end
      ST_DIVIDE: begin
        if (div_done) state_next = (filter == '0) ? ST_TRACK : ST_MUL_OLD;
      end
      ST_MUL_OLD: state_next = ST_MUL_NEW;
      ST_MUL_NEW: state_next = ST_SUM;
      ST_SUM:     state_next = ST_TRACK;
      ST_TRACK: begin
        if (out_free) begin
          trk_step   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      filter    <= '0;
      out_valid <= 1'b0;
    end else begin
      if (state == ST_DIVIDE && div_done && filter == '0) begin
        filter <= rd_clamped;
      end else if (state == ST_SUM) begin
        filter <= ema_sum[PROD_W-1:FRAC_W];
      end
      if (trk_step) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && in_valid) begin
      vref_q <= vref_raw;
      vbat_q <= vbat_raw;
    end
    if (state == ST_DIVIDE && div_done) begin
      rd <= rd_clamped;
    end
    if (state == ST_MUL_OLD || state == ST_MUL_NEW) begin
      prod <= mul_a * mul_b;
    end
    if (state == ST_MUL_NEW) begin
      acc <= prod;
    end
    if (trk_step) begin
      out_q <= trk_result;
    end
  end

  assign filtered_mv      = out_q.mv;
  assign led_band         = out_q.band;
  assign band_changed     = out_q.changed;
  assign led_grb          = out_q.grb;
  assign heartbeat_report = out_q.hb;
  assign report_mv        = out_q.rep;
  assign stream_frame     = out_q.frame;
  assign frame_seq        = out_q.seq;
  assign alarm            = out_q.alarm;

  `ASSERT_IMPLIES(a_done_in_divide, clk, rst, div_done, state == ST_DIVIDE)
  `ASSERT_NEXT(a_accept_to_check, clk, rst, in_valid && !in_stall, state == ST_CHECK)
  `ASSERT_IMPLIES(a_result_from_track, clk, rst, $rose(out_valid), $past(state) == ST_TRACK)
  `ASSERT_IMPLIES(a_filter_in_range, clk, rst, 1'b1, filter <= RD_MAX[Q_W-1:0])

endmodule

/* dv/battery_voltage_monitor_tb.sv */
`timescale 1ns / 1ps

module battery_voltage_monitor_tb;
  import bvm_pkg::*;

  localparam int unsigned CLK_PERIOD = 12;
  localparam int unsigned TICK_MS = TICK_MS_DEF;
  localparam int unsigned ALARM_TICKS = 10000 / TICK_MS;
  localparam int unsigned SETTLE_CYCLES = 64;
  localparam int unsigned STALL_LIMIT = 4000;
  localparam int unsigned NUM_CHUNKS = 6;

  typedef struct packed {
    logic [11:0] vref;
    logic [11:0] vbat;
  } adc_tick_t;

  localparam logic [23:0] BAND_COLOUR [4] = '{24'h003000, 24'h103000, 24'h202000, 24'h300000};
  localparam int unsigned EDGE_MV [9] = '{7350, 7400, 7450, 7550, 7600, 7650, 7850, 7900, 7950};

  localparam adc_tick_t DIRECTED_TICKS [22] = '{
    '{12'd0, 12'd0}, '{12'd4095, 12'd4095}, '{12'd1, 12'd0}, '{12'd1, 12'd4095},
    '{12'd2, 12'd3}, '{12'd2, 12'd4}, '{12'd1331, 12'd2000}, '{12'd1331, 12'd2001},
    '{12'd4094, 12'd4095}, '{12'd4094, 12'd0}, '{12'd0, 12'd4095}, '{12'd4095, 12'd1},
    '{12'd1502, 12'd903}, '{12'd1502, 12'd880}, '{12'd1502, 12'd850}, '{12'd1502, 12'd700},
    '{12'd3000, 12'd4095}, '{12'd1000, 12'd1}, '{12'd2048, 12'd2048}, '{12'd4095, 12'd0},
    '{12'd1, 12'd1}, '{12'd100, 12'd100}
  };

  localparam int unsigned CHUNK_ITEMS [NUM_CHUNKS] = '{300, 700, 250, 250, 250, 250};
  localparam int unsigned CHUNK_HB [NUM_CHUNKS] = '{100, 65535, 1, 0, 350, 250};
  localparam int unsigned CHUNK_LOW [NUM_CHUNKS] = '{7000, 20000, 0, 6300, 8000, 12000};
  localparam int unsigned CHUNK_EN [NUM_CHUNKS] = '{1, 1, 0, 1, 1, 1};
  localparam int unsigned CHUNK_SP [NUM_CHUNKS] = '{0, 65535, 100, 99, 250, 1000};

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [11:0] vref_raw = '0;
  logic [11:0] vbat_raw = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [14:0] filtered_mv;
  logic [1:0] led_band;
  logic band_changed;
  logic [23:0] led_grb;
  logic heartbeat_report;
  logic [14:0] report_mv;
  logic stream_frame;
  logic [15:0] frame_seq;
  logic alarm;
  logic cfg_we = 1'b0;
  reg_index_t cfg_index = REG_HB_PERIOD;
  logic [15:0] cfg_data = '0;

  adc_tick_t pending_ticks[$];
  trk_result_t expected_results[$];
  int unsigned src_idle_pct = 6;
  int unsigned sink_stall_pct = 46;
  int unsigned fail_count = 0;
  int unsigned quiet_cycles = 0;

  int unsigned report_period = 0;
  logic [14:0] low_limit = 15'd6300;
  logic frames_on = 1'b0;
  int unsigned frame_period = 0;
  logic [30:0] filter_q16 = '0;
  logic [1:0] band_now = BAND_RED;
  logic band_known = 1'b0;
  int unsigned report_elapsed = 0;
  int unsigned low_ticks = 0;
  int unsigned frame_elapsed = 0;
  logic [15:0] next_frame_seq = '0;

  battery_voltage_monitor dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .vref_raw(vref_raw),
    .vbat_raw(vbat_raw),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .filtered_mv(filtered_mv),
    .led_band(led_band),
    .band_changed(band_changed),
    .led_grb(led_grb),
    .heartbeat_report(heartbeat_report),
    .report_mv(report_mv),
    .stream_frame(stream_frame),
    .frame_seq(frame_seq),
    .alarm(alarm),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  function automatic logic [1:0] classify_band(logic [14:0] v);
    logic [1:0] b;
    b = band_now;
    if (!band_known) begin
      if (v < TH_LO) b = BAND_RED;
      else if (v < TH_MID) b = BAND_ORANGE;
      else if (v < TH_HI) b = BAND_YELLOW;
      else b = BAND_GREEN;
    end else begin
      case (band_now)
        BAND_GREEN: if (v < TH_HI - HYST) b = BAND_YELLOW;
        BAND_YELLOW: begin
          if (v >= TH_HI + HYST) b = BAND_GREEN;
          else if (v < TH_MID - HYST) b = BAND_ORANGE;
        end
        BAND_ORANGE: begin
          if (v >= TH_MID + HYST) b = BAND_YELLOW;
          else if (v < TH_LO - HYST) b = BAND_RED;
        end
        default: if (v >= TH_LO + HYST) b = BAND_ORANGE;
      endcase
    end
    return b;
  endfunction

  function automatic trk_result_t predict_tick(logic [11:0] vref, logic [11:0] vbat);
    logic [63:0] reading;
    int unsigned span;
    int unsigned per;
    trk_result_t r;
    r = '0;
    if (vref != 12'd0 && vref != VREF_HIGH) begin
      reading = (64'(vbat) * 64'(MV_SCALE)) << 16;
      reading = reading / 64'(vref);
      if (reading > 64'(RD_MAX)) reading = '0;
      if (filter_q16 == '0) filter_q16 = reading[30:0];
      else filter_q16 = 31'((64'(filter_q16) * 64'(EMA_OLD) + reading * 64'(EMA_NEW)) >> 16);
    end
    r.mv = filter_q16[30:16];
    r.rep = 15'((64'(filter_q16) + 64'd32768) >> 16);
    r.band = classify_band(r.mv);
    r.changed = !band_known || r.band != band_now;
    r.grb = BAND_COLOUR[r.band];
    band_now = r.band;
    band_known = 1'b1;

    if (report_period != 0) begin
      span = report_elapsed + TICK_MS;
      if (span >= report_period) begin
        report_elapsed = 0;
        r.hb = 1'b1;
      end else begin
        report_elapsed = span;
      end
    end else begin
      report_elapsed = 0;
    end

    if (64'(filter_q16) < (64'(low_limit) << 16) && filter_q16 > FLOOR_Q) low_ticks++;
    else low_ticks = 0;
    if (low_ticks > ALARM_TICKS) begin
      r.alarm = 1'b1;
      low_ticks = 0;
    end

    if (frames_on) begin
      per = (frame_period < TICK_MS) ? TICK_MS : frame_period;
      span = frame_elapsed + TICK_MS;
      if (span >= per) begin
        span = 0;
        r.frame = 1'b1;
        r.seq = next_frame_seq;
        next_frame_seq = next_frame_seq + 16'd1;
      end
      frame_elapsed = span;
    end
    return r;
  endfunction

  always @(posedge clk) begin : drive_ticks
    adc_tick_t tick;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) expected_results.push_back(predict_tick(vref_raw, vbat_raw));
      if (!in_valid || !in_stall) begin
        if (pending_ticks.size() != 0 && $urandom_range(0, 99) >= src_idle_pct) begin
          tick = pending_ticks.pop_front();
          in_valid <= 1'b1;
          vref_raw <= tick.vref;
          vbat_raw <= tick.vbat;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : check_results
    trk_result_t got;
    trk_result_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(0, 99) < sink_stall_pct);
      if (out_valid && !out_stall) begin
        got = {filtered_mv, led_band, band_changed, led_grb, heartbeat_report, report_mv,
               stream_frame, frame_seq, alarm};
        if (expected_results.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("result transfer with no pending expectation");
        end else begin
          want = expected_results.pop_front();
          if (got !== want) begin
            fail_count++;
            if (fail_count <= 10) begin
              $write("result mismatch (expected/actual): mv %0d/%0d band %0d/%0d ",
                     want.mv, got.mv, want.band, got.band);
              $write("changed %0d/%0d grb %h/%h hb %0d/%0d rep %0d/%0d ",
                     want.changed, got.changed, want.grb, got.grb, want.hb, got.hb,
                     want.rep, got.rep);
              $display("frame %0d/%0d seq %0d/%0d alarm %0d/%0d",
                       want.frame, got.frame, want.seq, got.seq, want.alarm, got.alarm);
            end
          end
        end
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  task automatic wait_idle();
    while (pending_ticks.size() != 0 || in_valid || expected_results.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(reg_index_t idx, logic [15:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    case (idx)
      REG_HB_PERIOD: report_period = value;
      REG_LOW_LIMIT: low_limit = value[14:0];
      REG_STREAM_EN: begin
        frames_on = value[0];
        frame_elapsed = 0;
        next_frame_seq = '0;
      end
      default: frame_period = value;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Each segment holds the battery near one voltage, some long enough for the
  // moving average to settle, so band edges and the alarm counter get exercised.
  task automatic fill_random(int unsigned count);
    int unsigned remaining;
    int unsigned target;
    int unsigned len;
    int unsigned cls;
    int unsigned roll;
    int unsigned vref;
    int unsigned vbat;
    adc_tick_t t;
    remaining = count;
    while (remaining != 0) begin
      cls = $urandom_range(0, 99);
      len = $urandom_range(3, 120);
      if (cls < 40) begin
        target = EDGE_MV[$urandom_range(0, 8)] + $urandom_range(0, 80) - 40;
      end else if (cls < 60) begin
        target = $urandom_range(4901, 12000);
        len = $urandom_range(100, 180);
      end else if (cls < 70) begin
        target = $urandom_range(20001, 60000);
      end else if (cls < 80) begin
        target = $urandom_range(0, 4900);
      end else begin
        target = $urandom_range(0, 20000);
      end
      if (len > remaining) len = remaining;
      repeat (len) begin
        roll = $urandom_range(0, 99);
        if (roll < 3) begin
          t.vref = $urandom_range(0, 1) ? 12'd4095 : 12'd0;
          t.vbat = $urandom_range(0, 4095);
        end else if (roll < 10) begin
          t.vref = $urandom_range(0, 4095);
          t.vbat = $urandom_range(0, 4095);
        end else begin
          vref = $urandom_range(1000, 3000);
          vbat = (target * vref + 6655) / 13310;
          if (vbat > 4095) vbat = 4095;
          t.vref = vref[11:0];
          t.vbat = vbat[11:0];
        end
        pending_ticks.push_back(t);
      end
      remaining -= len;
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    foreach (DIRECTED_TICKS[i]) pending_ticks.push_back(DIRECTED_TICKS[i]);

    for (int k = 0; k < NUM_CHUNKS; k++) begin
      wait_idle();
      src_idle_pct = (k < 2) ? 6 : (k < 4) ? 46 : 0;
      sink_stall_pct = (k < 2) ? 46 : (k < 4) ? 6 : 0;
      write_reg(REG_HB_PERIOD, CHUNK_HB[k][15:0]);
      write_reg(REG_LOW_LIMIT, CHUNK_LOW[k][15:0]);
      write_reg(REG_STREAM_EN, CHUNK_EN[k][15:0]);
      write_reg(REG_STREAM_PERIOD, CHUNK_SP[k][15:0]);
      fill_random(CHUNK_ITEMS[k]);
    end

    wait_idle();
    if (fail_count == 0 && expected_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+rtl
rtl/bvm_pkg.sv
rtl/bvm_divider.sv
rtl/bvm_track.sv
rtl/battery_voltage_monitor.sv
dv/battery_voltage_monitor_tb.sv
